[sv/reversible_circular_stack_core_assert.svh]
// Assertion macros shared by the checker
`ifndef REVERSIBLE_CIRCULAR_STACK_CORE_ASSERT_SVH
`define REVERSIBLE_CIRCULAR_STACK_CORE_ASSERT_SVH

// Clocked property, disabled while reset is held
`define RCS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition implies the given signal holds over the next cycle
`define RCS_ASSERT_HOLD(label, clk, rst_n, cond, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> $stable(sig)) else $error(msg);

`endif

[sv/rcs_pkg.sv]
`default_nettype none
package rcs_pkg;

    localparam int CMD_W      = 2;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int FILL_W     = 5;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 40;
    localparam int M_PAD_W    = M_TDATA_W - VALUE_W - FILL_W;

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_cmd CMD_PUSH    = 2'd0;
    localparam t_cmd CMD_POP     = 2'd1;
    localparam t_cmd CMD_PEEK    = 2'd2;
    localparam t_cmd CMD_REVERSE = 2'd3;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;   // latch the incoming transaction and read the top entry
        logic exec;   // carry out the command and load the result register
    } t_ctrl;

endpackage
`default_nettype wire

[sv/reversible_circular_stack_core.sv]
// A taken command is latched in the input register while the top entry is read; it then
// executes, updating the pointers and loading the result register offered on the master
// side. No new command is taken until it executes, held back only while a result waits.
// Reset: synchronous, active low; clears pointers, fill count, direction and valids.
// The entry store is not cleared and needs no clearing pass.
`default_nettype none
module reversible_circular_stack_core #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    input  wire logic [rcs_pkg::S_TDATA_W-1:0]    i_s_tdata,  // push_value
    input  wire logic [rcs_pkg::CMD_W-1:0]        i_s_tuser,  // cmd
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    output logic      [rcs_pkg::M_TDATA_W-1:0]    o_m_tdata,  // value, fill_count, pad
    output logic      [rcs_pkg::STATUS_W-1:0]     o_m_tuser   // status
);

    rcs_pkg::t_ctrl                 ctrl;
    logic [rcs_pkg::VALUE_W-1:0]    value;
    rcs_pkg::t_status               status;
    logic [rcs_pkg::FILL_W-1:0]     fill_count;

    rcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_ctrl     (ctrl)
    );

    rcs_datapath #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .i_cmd        (i_s_tuser),
        .i_push_value (i_s_tdata),
        .o_value      (value),
        .o_status     (status),
        .o_fill_count (fill_count)
    );

    assign o_m_tdata = {{rcs_pkg::M_PAD_W{1'b0}}, fill_count, value};
    assign o_m_tuser = status;

endmodule
`default_nettype wire

[sv/rcs_ram.sv]
`default_nettype none
module rcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[sv/rcs_ctrl.sv]
`default_nettype none
module rcs_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output rcs_pkg::t_ctrl     o_ctrl
);

    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_EXEC = 1'b1;

    logic [0:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state     = r_state;
        o_ctrl      = '0;
        o_s_tready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready  = 1'b1;
                if (i_s_tvalid) begin
                    o_ctrl.load = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    o_ctrl.exec = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_ctrl.exec) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule
`default_nettype wire

[sv/rcs_datapath.sv]
`default_nettype none
module rcs_datapath #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire rcs_pkg::t_ctrl                 i_ctrl,
    input  wire rcs_pkg::t_cmd                  i_cmd,
    input  wire logic [rcs_pkg::VALUE_W-1:0]    i_push_value,
    output logic      [rcs_pkg::VALUE_W-1:0]    o_value,
    output rcs_pkg::t_status                    o_status,
    output logic      [rcs_pkg::FILL_W-1:0]     o_fill_count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    rcs_pkg::t_cmd                 r_cmd;
    logic [rcs_pkg::VALUE_W-1:0]   r_push;
    logic [PTR_W-1:0]              r_top, n_top;
    logic [PTR_W-1:0]              r_bot, n_bot;
    logic                          r_rev, n_rev;
    logic [CNT_W-1:0]              r_count, n_count;
    logic [rcs_pkg::VALUE_W-1:0]   r_value, n_value;
    rcs_pkg::t_status              r_status, n_status;
    logic [rcs_pkg::FILL_W-1:0]    r_fill;

    logic [PTR_W-1:0]              top_up, top_dn;
    logic                          empty, full, we;
    logic [WORD_BITS-1:0]          rd_data, wr_data;
    logic [WORD_BITS+rcs_pkg::VALUE_W-1:0]  wr_ext, rd_ext;
    logic [CNT_W+rcs_pkg::FILL_W-1:0]       cnt_ext;

    assign empty  = (r_count == '0);
    assign full   = (r_count == CNT_FULL);
    assign top_up = (r_top == PTR_LAST) ? '0 : r_top + 1'b1;
    assign top_dn = (r_top == '0) ? PTR_LAST : r_top - 1'b1;

    assign wr_ext  = {{WORD_BITS{1'b0}}, r_push};
    assign wr_data = wr_ext[WORD_BITS-1:0];
    assign rd_ext  = {{rcs_pkg::VALUE_W{1'b0}}, rd_data};
    assign cnt_ext = {{rcs_pkg::FILL_W{1'b0}}, n_count};

    always_comb begin
        n_top    = r_top;
        n_bot    = r_bot;
        n_rev    = r_rev;
        n_count  = r_count;
        n_value  = '0;
        n_status = rcs_pkg::ST_OK;
        we       = 1'b0;
        case (r_cmd)
            rcs_pkg::CMD_PUSH: begin
                if (full) begin
                    n_status = rcs_pkg::ST_FULL;
                end else begin
                    n_top   = r_rev ? top_dn : top_up;
                    n_count = r_count + 1'b1;
                    we      = i_ctrl.exec;
                end
            end
            rcs_pkg::CMD_POP: begin
                if (empty) begin
                    n_status = rcs_pkg::ST_EMPTY;
                end else begin
                    n_value = rd_ext[rcs_pkg::VALUE_W-1:0];
                    n_top   = r_rev ? top_up : top_dn;
                    n_count = r_count - 1'b1;
                end
            end
            rcs_pkg::CMD_PEEK: begin
                if (empty) begin
                    n_status = rcs_pkg::ST_EMPTY;
                end else begin
                    n_value = rd_ext[rcs_pkg::VALUE_W-1:0];
                end
            end
            default: begin
                n_top = r_bot;
                n_bot = r_top;
                n_rev = !r_rev;
            end
        endcase
    end

    // entry store; read of the top entry is issued as the transaction is taken
    rcs_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (n_top),
        .i_wdata (wr_data),
        .i_re    (i_ctrl.load),
        .i_raddr (r_top),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top   <= PTR_LAST;
            r_bot   <= '0;
            r_rev   <= 1'b0;
            r_count <= '0;
        end else if (i_ctrl.exec) begin
            r_top   <= n_top;
            r_bot   <= n_bot;
            r_rev   <= n_rev;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd  <= i_cmd;
            r_push <= i_push_value;
        end
        if (i_ctrl.exec) begin
            r_value  <= n_value;
            r_status <= n_status;
            r_fill   <= cnt_ext[rcs_pkg::FILL_W-1:0];
        end
    end

    assign o_value      = r_value;
    assign o_status     = r_status;
    assign o_fill_count = r_fill;

endmodule
`default_nettype wire

[sv/rcs_checker.sv]
`default_nettype none
`include "reversible_circular_stack_core_assert.svh"
module rcs_checker #(
    parameter int DEPTH = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    input  wire logic                             i_s_tready,
    input  wire logic                             i_m_tvalid,
    input  wire logic                             i_m_tready,
    input  wire logic [rcs_pkg::M_TDATA_W-1:0]    i_m_tdata,
    input  wire logic [rcs_pkg::STATUS_W-1:0]     i_m_tuser
);

    logic s_acc, m_stall, st_known, m_err, val_zero, fill_ok;

    assign s_acc    = i_s_tvalid && i_s_tready;
    assign m_stall  = i_m_tvalid && !i_m_tready;
    assign st_known = (i_m_tuser == rcs_pkg::ST_OK) || (i_m_tuser == rcs_pkg::ST_EMPTY)
                   || (i_m_tuser == rcs_pkg::ST_FULL);
    assign m_err    = i_m_tvalid && (i_m_tuser != rcs_pkg::ST_OK);
    assign val_zero = (i_m_tdata[rcs_pkg::VALUE_W-1:0] == '0);
    assign fill_ok  = (DEPTH > 31)
                   || (32'(i_m_tdata[rcs_pkg::VALUE_W +: rcs_pkg::FILL_W]) <= 32'(DEPTH));

    `RCS_ASSERT_HOLD(a_m_hold, i_clk, i_rst_n, m_stall, i_m_tdata, "result changed while stalled")
    `RCS_ASSERT(a_single, i_clk, i_rst_n, s_acc |=> !i_s_tready, "input taken while busy")
    `RCS_ASSERT(a_status, i_clk, i_rst_n, i_m_tvalid |-> st_known, "undefined status code")
    `RCS_ASSERT(a_fill, i_clk, i_rst_n, i_m_tvalid |-> fill_ok, "fill count beyond capacity")
    `RCS_ASSERT(a_err_zero, i_clk, i_rst_n, m_err |-> val_zero, "value not zero on error")

endmodule

bind reversible_circular_stack_core rcs_checker #(.DEPTH(DEPTH)) u_rcs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser)
);
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    localparam int STACK_DEPTH  = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        logic [rcs_pkg::VALUE_W-1:0] value;
        rcs_pkg::t_status            status;
        logic [rcs_pkg::FILL_W-1:0]  fill;
    } t_stack_result;

    class stack_scoreboard;
        logic [rcs_pkg::VALUE_W-1:0] words [STACK_DEPTH];
        logic [3:0]                  top_ptr;
        logic [3:0]                  bottom_ptr;
        bit                          reversed;
        int unsigned                 held;
        t_stack_result               expected_q [$];
        int unsigned                 errors;

        function new();
            top_ptr    = 4'(STACK_DEPTH - 1);
            bottom_ptr = 4'd0;
            reversed   = 1'b0;
            held       = 0;
            errors     = 0;
        endfunction

        function void note_command(rcs_pkg::t_cmd cmd, logic [rcs_pkg::VALUE_W-1:0] word);
            t_stack_result r;
            logic [3:0]    swap;
            r.value  = '0;
            r.status = rcs_pkg::ST_OK;
            case (cmd)
                rcs_pkg::CMD_PUSH: begin
                    if (held >= STACK_DEPTH) begin
                        r.status = rcs_pkg::ST_FULL;
                    end else begin
                        top_ptr = reversed ? top_ptr - 4'd1 : top_ptr + 4'd1;
                        words[top_ptr] = word;
                        held++;
                    end
                end
                rcs_pkg::CMD_POP: begin
                    if (held == 0) begin
                        r.status = rcs_pkg::ST_EMPTY;
                    end else begin
                        r.value = words[top_ptr];
                        top_ptr = reversed ? top_ptr + 4'd1 : top_ptr - 4'd1;
                        held--;
                    end
                end
                rcs_pkg::CMD_PEEK: begin
                    if (held == 0)
                        r.status = rcs_pkg::ST_EMPTY;
                    else
                        r.value = words[top_ptr];
                end
                default: begin
                    swap       = top_ptr;
                    top_ptr    = bottom_ptr;
                    bottom_ptr = swap;
                    reversed   = !reversed;
                end
            endcase
            r.fill = rcs_pkg::FILL_W'(held);
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [rcs_pkg::VALUE_W-1:0] value,
                                   rcs_pkg::t_status status,
                                   logic [rcs_pkg::FILL_W-1:0] fill);
            t_stack_result exp_r;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result value %h status %0d fill %0d",
                         $time, value, status, fill);
                errors++;
            end else begin
                exp_r = expected_q.pop_front();
                if (value !== exp_r.value) begin
                    $display("%0t: value expected %h, got %h", $time, exp_r.value, value);
                    errors++;
                end
                if (status !== exp_r.status) begin
                    $display("%0t: status expected %0d, got %0d", $time, exp_r.status, status);
                    errors++;
                end
                if (fill !== exp_r.fill) begin
                    $display("%0t: fill_count expected %0d, got %0d", $time, exp_r.fill, fill);
                    errors++;
                end
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [rcs_pkg::S_TDATA_W-1:0] s_tdata = '0;                // push_value
    rcs_pkg::t_cmd                 s_tuser = rcs_pkg::CMD_PUSH; // cmd
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [rcs_pkg::M_TDATA_W-1:0] m_tdata;                     // value, fill_count, pad
    rcs_pkg::t_status              m_tuser;                     // status

    int unsigned     tx_idle_pct = 0;
    int unsigned     rx_stall_pct = 0;
    int unsigned     hold_requests = 0;
    int unsigned     hold_served = 0;
    int unsigned     hold_left = 0;
    int unsigned     quiet_cycles = 0;
    stack_scoreboard sb = new();

    reversible_circular_stack_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        if (s_tvalid && s_tready)
            sb.note_command(s_tuser, s_tdata);
        if (m_tvalid && m_tready)
            sb.check_result(m_tdata[rcs_pkg::VALUE_W-1:0], m_tuser,
                            m_tdata[rcs_pkg::VALUE_W +: rcs_pkg::FILL_W]);
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge clk) begin
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
                $display("reversible_circular_stack_core regression: fail");
                $finish;
            end
        end
    end

    task automatic send_cmd(input rcs_pkg::t_cmd cmd,
                            input logic [rcs_pkg::S_TDATA_W-1:0] word);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= word;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    function automatic logic [rcs_pkg::S_TDATA_W-1:0] pick_word();
        case ($urandom_range(15))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic rcs_pkg::t_cmd pick_cmd(input int unsigned push_pct);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)
            return rcs_pkg::CMD_REVERSE;
        if (r < 18)
            return rcs_pkg::CMD_PEEK;
        if (r < 18 + (82 * push_pct) / 100)
            return rcs_pkg::CMD_PUSH;
        return rcs_pkg::CMD_POP;
    endfunction

    // bursts with a drifting push/pop balance so the stack swings between empty and full
    task automatic run_random(input int unsigned count);
        int unsigned push_pct;
        push_pct = 50;
        for (int unsigned i = 0; i < count; i++) begin
            if (i % 32 == 0) begin
                case ($urandom_range(3))
                    0:       push_pct = 15;
                    1:       push_pct = 85;
                    2:       push_pct = 50;
                    default: push_pct = $urandom_range(100);
                endcase
            end
            send_cmd(pick_cmd(push_pct), pick_word());
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty stack, reverse on empty, extremes, then fill to capacity and overflow
        send_cmd(rcs_pkg::CMD_POP, $urandom);
        send_cmd(rcs_pkg::CMD_PEEK, $urandom);
        send_cmd(rcs_pkg::CMD_REVERSE, $urandom);
        send_cmd(rcs_pkg::CMD_PUSH, 32'h7FFF_FFFF);
        send_cmd(rcs_pkg::CMD_PUSH, 32'h8000_0000);
        send_cmd(rcs_pkg::CMD_PEEK, 32'h0);
        send_cmd(rcs_pkg::CMD_REVERSE, 32'h0);
        send_cmd(rcs_pkg::CMD_PEEK, 32'h0);
        send_cmd(rcs_pkg::CMD_POP, 32'h0);
        for (int i = 0; i < STACK_DEPTH - 1; i++) begin
            if (i == 0)
                send_cmd(rcs_pkg::CMD_PUSH, 32'h0000_0000);
            else if (i == 1)
                send_cmd(rcs_pkg::CMD_PUSH, 32'hFFFF_FFFF);
            else
                send_cmd(rcs_pkg::CMD_PUSH, $urandom);
        end
        send_cmd(rcs_pkg::CMD_PUSH, 32'h1234_5678);
        send_cmd(rcs_pkg::CMD_PEEK, 32'h0);
        wait_drained();

        tx_idle_pct  = 0;
        rx_stall_pct <= 0;
        run_random(100);
        hold_requests <= hold_requests + 1;
        run_random(200);
        wait_drained();

        tx_idle_pct  = 64;
        rx_stall_pct <= 0;
        run_random(310);
        wait_drained();

        tx_idle_pct  = 0;
        rx_stall_pct <= 64;
        run_random(310);
        wait_drained();

        tx_idle_pct  = 37;
        rx_stall_pct <= 37;
        run_random(310);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("reversible_circular_stack_core regression: pass");
        else
            $display("reversible_circular_stack_core regression: fail");
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/rcs_pkg.sv
sv/rcs_ram.sv
sv/rcs_ctrl.sv
sv/rcs_datapath.sv
sv/reversible_circular_stack_core.sv
sv/rcs_checker.sv
tb/tb_top.sv
